// ----- design/greedy_graph_coloring_assert.svh -----
// Assertion macros for the greedy graph coloring block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef GREEDY_GRAPH_COLORING_ASSERT_SVH
`define GREEDY_GRAPH_COLORING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GGC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define GGC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/gcol_pkg.sv -----
// Shared types and constants for the greedy graph coloring block.
// No dependencies; imported by every module of the block.
package gcol_pkg;

	// Sizes fixed by the item fields.
	localparam int MAX_VERTICES_DEF = 64;
	localparam int VIDX_W           = 6;
	localparam int COLOR_W          = 6;
	localparam int CNT_W            = 7;
	localparam int NUM_COLORS       = 64;
	localparam int CHUNK_W          = 8;
	localparam int NUM_CHUNKS       = NUM_COLORS / CHUNK_W;
	localparam int CHUNK_IDX_W      = $clog2(NUM_CHUNKS);
	localparam int CHUNK_POS_W      = $clog2(CHUNK_W);

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

	// Item actions.
	localparam logic ACT_COLOR = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEARCH
	} gcol_state_t;

	// Result of the free-color search over one chunk.
	typedef struct packed {
		logic                   found;
		logic [CHUNK_POS_W-1:0] pos;
	} ff_res_t;

endpackage

// ----- design/gcol_color_mem.sv -----
// Color table memory: one write port, one registered read port.
// Depends on gcol_pkg for the color width.
module gcol_color_mem
	import gcol_pkg::*;
#(
	parameter int DEPTH = MAX_VERTICES_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [COLOR_W-1:0]       wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [COLOR_W-1:0]       rd_data
);

	logic [COLOR_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- design/gcol_first_free.sv -----
// Find-first-zero over one chunk of the taken-color set.
// Depends on gcol_pkg for the chunk size and result struct.
module gcol_first_free
	import gcol_pkg::*;
(
	input  logic [CHUNK_W-1:0] bits,
	output ff_res_t            res
);

	// Lowest clear bit wins; with none clear the position reads all ones.
	always_comb begin
		res.found = 1'b0;
		res.pos   = '1;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				res.found = 1'b1;
				res.pos   = CHUNK_POS_W'(i);
			end
		end
	end

endmodule

// ----- design/greedy_graph_coloring.sv -----
// Top level of the greedy graph coloring block: sequencer, scan datapath, APB register.
// Depends on gcol_pkg, gcol_color_mem and gcol_first_free.
//
// Channel   Ports                                             Handshake
// input     action, vertex_index, neighbor_mask               start high while busy low
// result    vertex_index_res, color, colors_used              done high for one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata      APB, pready always high
//
// A color item scans the neighbor slots, one table read per neighbor slot through
// the single color table port, then searches for a free color at eight colors per
// cycle; done follows in the cycle after the search ends.
// A clear item raises done in the cycle after it is accepted. busy is low again in the
// cycle that shows done. Reset clears all colored flags at once; no sweep is needed.
module greedy_graph_coloring
	import gcol_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input item
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  logic [VIDX_W-1:0]     vertex_index,
	input  logic [63:0]           neighbor_mask,
	// Result item
	output logic                  done,
	output logic [VIDX_W-1:0]     vertex_index_res,
	output logic [COLOR_W-1:0]    color,
	output logic [CNT_W-1:0]      colors_used,
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int SCAN_W = $clog2(MAX_VERTICES + 1);

	gcol_state_t state_q, state_d;

	logic [CNT_W-1:0]        vcount_q;
	logic [MAX_VERTICES-1:0] colored_q;
	logic [CNT_W-1:0]        max_q;
	logic [VIDX_W-1:0]       vidx_q;
	logic [MAX_VERTICES-1:0] mask_q;
	logic [SCAN_W-1:0]       scan_cnt_q;
	logic                    hit_q;
	logic [NUM_COLORS-1:0]   taken_q;
	logic [CHUNK_IDX_W-1:0]  chunk_q;
	logic                    done_q;

	logic                    accept;
	logic                    accept_color;
	logic                    accept_clear;
	logic                    in_scan;
	logic                    in_search;
	logic                    scan_last;
	logic                    finish;
	logic                    vidx_in_range;
	logic [MAX_VERTICES-1:0] init_mask;
	logic [IDX_W-1:0]        rd_addr;
	logic [COLOR_W-1:0]      rd_data;
	logic [COLOR_W-1:0]      new_color;
	logic [CNT_W-1:0]        color_p1;
	logic [CNT_W-1:0]        new_max;
	logic                    cfg_wr;
	ff_res_t                 ff_res;

	// Handshake decode.
	assign accept       = start && (state_q == ST_IDLE);
	assign accept_color = accept && (action == ACT_COLOR);
	assign accept_clear = accept && (action == ACT_CLEAR);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_color) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy      = 1'b1;
		in_scan   = 1'b0;
		in_search = 1'b0;
		case (state_q)
			ST_IDLE:   busy      = 1'b0;
			ST_SCAN:   in_scan   = 1'b1;
			ST_SEARCH: in_search = 1'b1;
			default:   busy      = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Neighbors worth reading: in range of the count, not the vertex itself, already colored.
	always_comb begin
		for (int j = 0; j < MAX_VERTICES; j++) begin
			init_mask[j] = neighbor_mask[j] && (vcount_q > CNT_W'(j)) &&
				(vertex_index != VIDX_W'(j)) && colored_q[j];
		end
	end

	// Scan control: one table read per slot, the data arrives in the next cycle.
	assign scan_last = (scan_cnt_q == SCAN_W'(MAX_VERTICES));
	assign rd_addr   = scan_last ? '0 : scan_cnt_q[IDX_W-1:0];

	gcol_color_mem #(
		.DEPTH(MAX_VERTICES)
	) u_mem (
		.clk     (clk),
		.wr_en   (finish && vidx_in_range),
		.wr_addr (vidx_q[IDX_W-1:0]),
		.wr_data (new_color),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Free-color search looks at the low chunk of the shifting taken set.
	gcol_first_free u_ff (
		.bits (taken_q[CHUNK_W-1:0]),
		.res  (ff_res)
	);

	assign finish        = in_search && (ff_res.found || (chunk_q == CHUNK_IDX_W'(NUM_CHUNKS - 1)));
	assign new_color     = {chunk_q, ff_res.pos};
	assign color_p1      = {1'b0, new_color} + CNT_W'(1);
	assign new_max       = (color_p1 > max_q) ? color_p1 : max_q;
	assign vidx_in_range = ({1'b0, vidx_q} < CNT_W'(MAX_VERTICES));

	// Scan and search datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			hit_q      <= 1'b0;
			chunk_q    <= '0;
		end else if (accept_color) begin
			scan_cnt_q <= '0;
			hit_q      <= 1'b0;
			chunk_q    <= '0;
		end else if (in_scan) begin
			if (!scan_last) begin
				scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
				hit_q      <= mask_q[0];
			end else begin
				hit_q <= 1'b0;
			end
		end else if (in_search && !finish) begin
			chunk_q <= chunk_q + CHUNK_IDX_W'(1);
		end
	end

	// Payload side of the datapath.
	always_ff @(posedge clk) begin
		if (accept_color) begin
			mask_q  <= init_mask;
			taken_q <= '0;
			vidx_q  <= vertex_index;
		end else if (in_scan) begin
			mask_q <= mask_q >> 1;
			if (hit_q) begin
				taken_q <= taken_q | (NUM_COLORS'(1) << rd_data);
			end
		end else if (in_search) begin
			taken_q <= taken_q >> CHUNK_W;
		end
	end

	// Colored flags and the running color count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colored_q <= '0;
			max_q     <= '0;
		end else if (accept_clear) begin
			colored_q <= '0;
			max_q     <= '0;
		end else if (finish) begin
			max_q <= new_max;
			for (int j = 0; j < MAX_VERTICES; j++) begin
				if (vidx_q == VIDX_W'(j)) colored_q[j] <= 1'b1;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish || accept_clear;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept_clear) begin
			vertex_index_res <= '0;
			color            <= '0;
			colors_used      <= '0;
		end else if (finish) begin
			vertex_index_res <= vidx_q;
			color            <= new_color;
			colors_used      <= new_max;
		end
	end

	assign done = done_q;

	// Configuration register.
	assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VERTEX_COUNT_RST;
		end else if (cfg_wr) begin
			vcount_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1] == REG_VERTEX_COUNT) ?
		{{(APB_DATA_W - CNT_W){1'b0}}, vcount_q} : '0;
	assign pready = 1'b1;

endmodule

// ----- design/gcol_checker.sv -----
// Port-level checker for the greedy graph coloring block, bound to the top level.
// Depends on gcol_pkg and greedy_graph_coloring_assert.svh.
`include "greedy_graph_coloring_assert.svh"

module gcol_checker
	import gcol_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [VIDX_W-1:0]  vertex_index_res,
	input logic [COLOR_W-1:0] color,
	input logic [CNT_W-1:0]   colors_used
);

	// A color result lies below the count; a clear result is all zero.
	`GGC_ASSERT_IMP(a_count_covers_color, done, (colors_used > {1'b0, color}) || ((colors_used == '0) && (color == '0) && (vertex_index_res == '0)), "colors_used does not cover color")

	// An accepted item either starts work or answers at once.
	`GGC_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "accepted item neither busy nor done")

	// Results only show while the block is ready.
	`GGC_ASSERT_IMP(a_done_not_busy, done, !busy, "done while busy")

	// Leaving the busy state always delivers the item.
	`GGC_ASSERT_IMP(a_fell_busy_done, $fell(busy), done, "busy dropped without a result")

endmodule

bind greedy_graph_coloring gcol_checker u_gcol_checker (.*);
